[rtl/core/are_pkg.sv]
// Package for the arithmetic range encoder core.
// Holds the code constants, the controller state type and the command and status structs.
// No dependencies.
package are_pkg;

    localparam int unsigned CodeBits   = 32;
    localparam int unsigned MaxPending = 127;
    localparam int unsigned PendBits   = 7;
    localparam int unsigned GuardBits  = 6;
    localparam int unsigned DivSteps   = 2 * CodeBits;
    localparam int unsigned CntBits    = 6;

    localparam logic [PendBits-1:0]  PendMax   = PendBits'(MaxPending);
    localparam logic [GuardBits-1:0] GuardMax  = GuardBits'(CodeBits);
    localparam logic [CntBits-1:0]   DivLast   = CntBits'(DivSteps - 1);
    localparam logic [CodeBits-1:0]  HighReset = '1;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RANGE  = 13'b0000000000010,
        S_MUL_LO = 13'b0000000000100,
        S_MUL_HI = 13'b0000000001000,
        S_DIV    = 13'b0000000010000,
        S_NARROW = 13'b0000000100000,
        S_NORM   = 13'b0000001000000,
        S_PEND   = 13'b0000010000000,
        S_RESC   = 13'b0000100000000,
        S_FIN    = 13'b0001000000000,
        S_FPEND  = 13'b0010000000000,
        S_FLUSH  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic range_calc;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic narrow;
        logic norm_step;
        logic pend_step;
        logic resc_step;
        logic guard_clr;
        logic fin_step;
        logic flush;
        logic release_last;
    } t_cmd;

    typedef struct packed {
        logic tot_zero;
        logic div_last;
        logic norm_ok;
        logic resc_ok;
        logic pend_nz;
        logic pend_one;
        logic eom;
        logic can_push;
    } t_status;

endpackage

[rtl/core/are_if.sv]
// Channel interfaces of the arithmetic range encoder core: symbol requests in, bytes out.
// No dependencies.
interface are_sym_if;
    logic        valid;
    logic        ready;
    logic [31:0] sym_low;
    logic [31:0] sym_high;
    logic [31:0] total;
    logic        end_of_message;

    modport source (output valid, sym_low, sym_high, total, end_of_message, input ready);
    modport sink   (input valid, sym_low, sym_high, total, end_of_message, output ready);
endinterface

interface are_byte_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    logic       pending_overflow;

    modport source (output valid, byte_valid, out_byte, run_last, message_end, pending_overflow,
                    input ready);
    modport sink   (input valid, byte_valid, out_byte, run_last, message_end, pending_overflow,
                    output ready);
endinterface

[rtl/core/arithmetic_range_encoder_core.sv]
// Top level of the arithmetic range encoder core: controller plus datapath.
// Depends on are_pkg, are_if, are_ctrl and are_dpath.
//
//  Channel   Dir   Handshake      Carries
//  i_sym     in    valid/ready    sym_low, sym_high, total, end_of_message
//  o_byte    out   valid/ready    byte_valid, out_byte, run_last, message_end, pending_overflow
//
// One request at a time: narrowing (accept, range, two multiplies, 64 divider steps shared
// by both bounds, narrow) when total is non-zero, only accept and range otherwise, then
// the emitted bits and rescale steps one at a time, plus bookkeeping.
// Synchronous active-low reset; no clearing pass is needed.
// A stalled output holds one byte in the output register and one more in reserve; the
// bit packer waits while both are full.
module arithmetic_range_encoder_core (
    input logic i_clk,
    input logic i_rst_n,
    are_sym_if.sink    i_sym,
    are_byte_if.source o_byte
);
    import are_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    are_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sym.valid),
        .o_in_ready (i_sym.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    are_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_sym_low          (i_sym.sym_low),
        .i_sym_high         (i_sym.sym_high),
        .i_total            (i_sym.total),
        .i_eom              (i_sym.end_of_message),
        .i_out_ready        (o_byte.ready),
        .o_out_valid        (o_byte.valid),
        .o_out_byte         (o_byte.out_byte),
        .o_run_last         (o_byte.run_last),
        .o_message_end      (o_byte.message_end),
        .o_pending_overflow (o_byte.pending_overflow)
    );

    assign o_byte.byte_valid = 1'b1;

endmodule

[rtl/core/are_ctrl.sv]
// Controller of the arithmetic range encoder: sequences narrowing, division,
// normalisation, rescaling and finishing. Depends on are_pkg.
module are_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  are_pkg::t_status i_status,
    output are_pkg::t_cmd   o_cmd
);
    import are_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_status.tot_zero) begin
                    n_state = S_NORM;
                end else begin
                    o_cmd.range_calc = 1'b1;
                    n_state          = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_NARROW;
                end
            end
            S_NARROW: begin
                o_cmd.narrow = 1'b1;
                n_state      = S_NORM;
            end
            S_NORM: begin
                if (!i_status.norm_ok) begin
                    o_cmd.guard_clr = 1'b1;
                    n_state         = S_RESC;
                end else if (i_status.can_push) begin
                    o_cmd.norm_step = 1'b1;
                    n_state         = i_status.pend_nz ? S_PEND : S_NORM;
                end
            end
            S_PEND: begin
                if (i_status.can_push) begin
                    o_cmd.pend_step = 1'b1;
                    if (i_status.pend_one) begin
                        n_state = S_NORM;
                    end
                end
            end
            S_RESC: begin
                if (i_status.resc_ok) begin
                    o_cmd.resc_step = 1'b1;
                end else begin
                    n_state = i_status.eom ? S_FIN : S_DONE;
                end
            end
            S_FIN: begin
                if (i_status.can_push) begin
                    o_cmd.fin_step = 1'b1;
                    n_state        = S_FPEND;
                end
            end
            S_FPEND: begin
                if (i_status.can_push) begin
                    o_cmd.pend_step = 1'b1;
                    if (i_status.pend_one) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.can_push) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.can_push) begin
                    o_cmd.release_last = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/are_dpath.sv]
// Datapath of the arithmetic range encoder: coding bounds, multiplier, two
// restoring dividers, bit packer and byte output stages. Depends on are_pkg.
module are_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  are_pkg::t_cmd    i_cmd,
    output are_pkg::t_status o_status,
    input  logic [31:0]      i_sym_low,
    input  logic [31:0]      i_sym_high,
    input  logic [31:0]      i_total,
    input  logic             i_eom,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_message_end,
    output logic             o_pending_overflow
);
    import are_pkg::*;

    // Request payload
    logic [CodeBits-1:0] r_sl, r_su, r_tot;
    logic                r_eom;
    // Coding state
    logic [CodeBits-1:0] r_low, r_high;
    logic [PendBits-1:0] r_pending;
    logic [7:0]          r_partial;
    logic [2:0]          r_pos;
    logic                r_ovf;
    logic                r_bit;
    logic [GuardBits-1:0] r_guard;
    // Range, product and dividers
    logic [CodeBits:0]     r_mag;
    logic                  r_neg;
    logic [2*CodeBits-1:0] r_dvd_a, r_dvd_b;
    logic [CodeBits-1:0]   r_rem_a, r_rem_b, r_q_a, r_q_b;
    logic [CntBits-1:0]    r_cnt;
    // Held byte and output register
    logic       r_hold_v, r_hold_end, r_hold_ovf;
    logic [7:0] r_hold_byte;
    logic       r_out_v, r_out_last, r_out_end, r_out_ovf;
    logic [7:0] r_out_byte;

    logic [CodeBits+1:0]   n_diff;
    logic [CodeBits-1:0]   n_op;
    logic [2*CodeBits-1:0] n_mult, n_prod;
    logic [CodeBits:0]     n_sh_a, n_sh_b;
    logic                  n_ge_a, n_ge_b;
    logic                  n_put, n_val, n_push, n_push_end;
    logic [7:0]            n_byte, n_push_byte;
    logic                  n_can_push, n_out_free;

    always_comb begin
        n_diff = {2'b00, r_high} - {2'b00, r_low} + (CodeBits+2)'(1);
        n_op   = i_cmd.mul_hi ? r_su : r_sl;
        n_mult = (2*CodeBits)'(n_op) * (2*CodeBits)'(r_mag[CodeBits-1:0]);
        n_prod = r_mag[CodeBits] ? {n_op, {CodeBits{1'b0}}} : n_mult;
        // A wrapped interval (high below low) gives a negative range, so the product is negated modulo 2^64.
        if (r_neg) begin
            n_prod = -n_prod;
        end
        n_sh_a = {r_rem_a, r_dvd_a[2*CodeBits-1]};
        n_sh_b = {r_rem_b, r_dvd_b[2*CodeBits-1]};
        n_ge_a = n_sh_a >= {1'b0, r_tot};
        n_ge_b = n_sh_b >= {1'b0, r_tot};
    end

    always_comb begin
        n_put  = i_cmd.norm_step | i_cmd.pend_step | i_cmd.fin_step;
        n_val  = i_cmd.norm_step ? r_low[CodeBits-1] :
                 i_cmd.fin_step  ? r_low[CodeBits-2] : r_bit;
        n_byte = r_partial | (8'(n_val) << r_pos);
        n_push      = (n_put && (r_pos == 3'd7)) || i_cmd.flush;
        n_push_byte = i_cmd.flush ? r_partial : n_byte;
        n_push_end  = i_cmd.flush;
        n_out_free  = !r_out_v || i_out_ready;
        n_can_push  = !r_hold_v || n_out_free;
    end

    assign o_status.tot_zero = (r_tot == '0);
    assign o_status.div_last = (r_cnt == DivLast);
    assign o_status.norm_ok  = (r_low[CodeBits-1] == r_high[CodeBits-1]) && (r_guard <= GuardMax);
    assign o_status.resc_ok  = (r_low[CodeBits-1:CodeBits-2] == 2'b01)
                            && (r_high[CodeBits-1:CodeBits-2] == 2'b10) && (r_guard <= GuardMax);
    assign o_status.pend_nz  = (r_pending != '0);
    assign o_status.pend_one = (r_pending == PendBits'(1));
    assign o_status.eom      = r_eom;
    assign o_status.can_push = n_can_push;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sl  <= i_sym_low;
            r_su  <= i_sym_high;
            r_tot <= i_total;
            r_eom <= i_eom;
        end
        if (i_cmd.range_calc) begin
            r_neg <= n_diff[CodeBits+1];
            r_mag <= n_diff[CodeBits+1] ? (CodeBits+1)'(-n_diff) : n_diff[CodeBits:0];
        end
        if (i_cmd.mul_lo) begin
            r_dvd_a <= n_prod;
            r_rem_a <= '0;
            r_cnt   <= '0;
        end
        if (i_cmd.mul_hi) begin
            r_dvd_b <= n_prod;
            r_rem_b <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd_a <= {r_dvd_a[2*CodeBits-2:0], 1'b0};
            r_dvd_b <= {r_dvd_b[2*CodeBits-2:0], 1'b0};
            r_rem_a <= n_ge_a ? CodeBits'(n_sh_a - {1'b0, r_tot}) : n_sh_a[CodeBits-1:0];
            r_rem_b <= n_ge_b ? CodeBits'(n_sh_b - {1'b0, r_tot}) : n_sh_b[CodeBits-1:0];
            r_q_a   <= {r_q_a[CodeBits-2:0], n_ge_a};
            r_q_b   <= {r_q_b[CodeBits-2:0], n_ge_b};
            r_cnt   <= r_cnt + CntBits'(1);
        end
        // Pending bits all take the opposite of the bit that was emitted before them.
        if (i_cmd.norm_step || i_cmd.fin_step) begin
            r_bit <= ~n_val;
        end
        if (n_push) begin
            r_hold_byte <= n_push_byte;
            r_hold_end  <= n_push_end;
            r_hold_ovf  <= r_ovf;
        end
        if ((n_push || i_cmd.release_last) && r_hold_v) begin
            r_out_byte <= r_hold_byte;
            r_out_end  <= r_hold_end;
            r_out_ovf  <= r_hold_ovf;
            r_out_last <= i_cmd.release_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= '0;
            r_high    <= HighReset;
            r_pending <= '0;
            r_partial <= '0;
            r_pos     <= '0;
            r_ovf     <= 1'b0;
            r_guard   <= '0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.guard_clr) begin
                r_guard <= '0;
            end
            if (i_cmd.narrow) begin
                r_high  <= r_low + r_q_b - CodeBits'(1);
                r_low   <= r_low + r_q_a;
                r_guard <= '0;
            end
            if (i_cmd.norm_step) begin
                r_low   <= {r_low[CodeBits-2:0], 1'b0};
                r_high  <= {r_high[CodeBits-2:0], 1'b1};
                r_guard <= r_guard + GuardBits'(1);
            end
            if (i_cmd.resc_step) begin
                r_low   <= {1'b0, r_low[CodeBits-3:0], 1'b0};
                r_high  <= {1'b1, r_high[CodeBits-3:0], 1'b1};
                r_guard <= r_guard + GuardBits'(1);
            end
            if (i_cmd.resc_step || i_cmd.fin_step) begin
                if (r_pending < PendMax) begin
                    r_pending <= r_pending + PendBits'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.pend_step) begin
                r_pending <= r_pending - PendBits'(1);
            end
            if (n_put) begin
                if (r_pos == 3'd7) begin
                    r_partial <= '0;
                    r_pos     <= '0;
                end else begin
                    r_partial <= n_byte;
                    r_pos     <= r_pos + 3'd1;
                end
            end
            // End of message returns the bounds, pending count, bit packer and overflow flag to their reset values.
            if (i_cmd.flush) begin
                r_low     <= '0;
                r_high    <= HighReset;
                r_pending <= '0;
                r_partial <= '0;
                r_pos     <= '0;
                r_ovf     <= 1'b0;
            end
            if (n_push) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.release_last) begin
                r_hold_v <= 1'b0;
            end
            if ((n_push || i_cmd.release_last) && r_hold_v) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_out_byte         = r_out_byte;
    assign o_run_last         = r_out_last;
    assign o_message_end      = r_out_end;
    assign o_pending_overflow = r_out_ovf;

`ifndef SYNTHESIS
    a_div_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem_a < r_tot) && (r_rem_b < r_tot))
        else $error("divider remainder not below total");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_pos == '0) && (r_pending == '0) && !r_ovf && r_hold_v)
        else $error("flush left coding state behind");
    a_hold_kept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_v && r_out_v && !i_out_ready) |=> r_hold_v && $stable(r_hold_byte))
        else $error("held byte lost while output stalled");
    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.resc_step && (r_pending == PendMax) |=> r_ovf && (r_pending == PendMax))
        else $error("pending count passed saturation");
`endif

endmodule

[bench/tb_are_checker.sv]
// Checker for the arithmetic range encoder core: predicts the code bytes of each symbol request
// and compares them with the bytes that leave the block.
// Depends on are_pkg and are_if.
module tb_are_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    are_sym_if.sink    i_sym_mon,
    are_byte_if.sink   i_byte_mon,
    output int         o_errors,
    output int         o_pending
);
    import are_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       msg_end;
        logic       ovf;
    } t_code_byte;

    t_code_byte exp_bytes[$];
    t_code_byte run_bytes[$];

    logic [CodeBits-1:0] enc_low;
    logic [CodeBits-1:0] enc_high;
    int unsigned         enc_pend;
    logic [7:0]          enc_acc;
    int unsigned         enc_pos;
    logic                enc_ovf;

    int errors;

    assign o_errors  = errors;
    assign o_pending = exp_bytes.size();

    task automatic clear_coder();
        enc_low  = '0;
        enc_high = '1;
        enc_pend = 0;
        enc_acc  = '0;
        enc_pos  = 0;
        enc_ovf  = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic fin);
        t_code_byte e;
        e.code    = b;
        e.last    = 1'b0;
        e.msg_end = fin;
        e.ovf     = enc_ovf;
        run_bytes.push_back(e);
    endtask

    task automatic shift_bit(input logic b);
        if (b) begin
            enc_acc[enc_pos] = 1'b1;
        end
        enc_pos++;
        if (enc_pos == 8) begin
            emit_byte(enc_acc, 1'b0);
            enc_acc = '0;
            enc_pos = 0;
        end
    endtask

    task automatic grow_pending();
        if (enc_pend < MaxPending) begin
            enc_pend++;
        end else begin
            enc_ovf = 1'b1;
        end
    endtask

    task automatic encode_symbol(input logic [31:0] s_lo, input logic [31:0] s_hi,
                                 input logic [31:0] tot, input logic eom);
        logic [63:0] span;
        logic [63:0] scl;
        logic [63:0] scu;
        logic        b;
        int          guard;
        t_code_byte  e;
        run_bytes.delete();
        if (tot != 0) begin
            span = {32'd0, enc_high} - {32'd0, enc_low} + 64'd1;
            scl  = ({32'd0, s_lo} * span) / {32'd0, tot};
            scu  = ({32'd0, s_hi} * span) / {32'd0, tot};
            enc_high = enc_low + scu[31:0] - 32'd1;
            enc_low  = enc_low + scl[31:0];
        end
        guard = 0;
        while (enc_low[31] == enc_high[31] && guard <= CodeBits) begin
            b = enc_low[31];
            shift_bit(b);
            while (enc_pend > 0) begin
                shift_bit(!b);
                enc_pend--;
            end
            enc_low  = enc_low << 1;
            enc_high = (enc_high << 1) | 32'd1;
            guard++;
        end
        guard = 0;
        while (enc_low[31:30] == 2'b01 && enc_high[31:30] == 2'b10 && guard <= CodeBits) begin
            grow_pending();
            enc_low  = (enc_low << 1) & 32'h7FFF_FFFF;
            enc_high = (enc_high << 1) | 32'h8000_0001;
            guard++;
        end
        if (eom) begin
            b = enc_low[30];
            shift_bit(b);
            grow_pending();
            while (enc_pend > 0) begin
                shift_bit(!b);
                enc_pend--;
            end
            emit_byte(enc_acc, 1'b1);
            clear_coder();
        end
        for (int k = 0; k < run_bytes.size(); k++) begin
            e = run_bytes[k];
            e.last = (k == run_bytes.size() - 1);
            exp_bytes.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_code_byte e;
        t_code_byte got;
        if (!i_rst_n) begin
            clear_coder();
            exp_bytes.delete();
            errors <= 0;
        end else begin
            if (i_sym_mon.valid && i_sym_mon.ready) begin
                encode_symbol(i_sym_mon.sym_low, i_sym_mon.sym_high, i_sym_mon.total,
                              i_sym_mon.end_of_message);
            end
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                got.code    = i_byte_mon.out_byte;
                got.last    = i_byte_mon.run_last;
                got.msg_end = i_byte_mon.message_end;
                got.ovf     = i_byte_mon.pending_overflow;
                if (exp_bytes.size() == 0) begin
                    if (errors < 10) begin
                        $display("checker: unexpected byte %h", got.code);
                    end
                    errors <= errors + 1;
                end else begin
                    e = exp_bytes.pop_front();
                    if (got != e || i_byte_mon.byte_valid !== 1'b1) begin
                        if (errors < 10) begin
                            $display("checker: byte exp %h last %b end %b ovf %b, got %h %b %b %b v%b",
                                     e.code, e.last, e.msg_end, e.ovf, got.code, got.last,
                                     got.msg_end, got.ovf, i_byte_mon.byte_valid);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/tb_top.sv]
// Testbench top for the arithmetic range encoder core: drives symbol requests with idling
// phases and stalls, and reports the verdict. Depends on are_pkg, are_if and tb_are_checker.
module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   send_idle = 0;
    int   stall_pct = 0;
    int   hold_off = 0;

    are_sym_if  sym_ch();
    are_byte_if byte_ch();

    always #4 i_clk = ~i_clk;

    arithmetic_range_encoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch.sink),
        .o_byte  (byte_ch.source)
    );

    tb_are_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sym_mon  (sym_ch.sink),
        .i_byte_mon (byte_ch.sink),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        sym_ch.valid          = 1'b0;
        sym_ch.sym_low        = '0;
        sym_ch.sym_high       = '0;
        sym_ch.total          = '0;
        sym_ch.end_of_message = 1'b0;
        byte_ch.ready         = 1'b0;
    end

    // Receiver: random stalls at the set rate, or a long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            byte_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            byte_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Valid stays high after an accepted request until the next request or an idle cycle
    // replaces it; the block stays busy after each acceptance.
    task automatic send_symbol(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] tot, input logic eom);
        while ($urandom_range(99) < send_idle) begin
            sym_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sym_ch.valid          <= 1'b1;
        sym_ch.sym_low        <= lo;
        sym_ch.sym_high       <= hi;
        sym_ch.total          <= tot;
        sym_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!sym_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Mostly well-formed symbols with varied model sizes; some with bad bounds.
    task automatic random_symbol();
        logic [31:0] tot;
        logic [31:0] lo;
        logic [31:0] hi;
        int          kind;
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0: tot = $urandom_range(255, 1);
            1: tot = $urandom_range(65535, 1);
            2: tot = $urandom();
            default: tot = 32'hFFFF_FFFF - $urandom_range(15);
        endcase
        if (tot == 0) begin
            tot = 1;
        end
        if (kind < 85) begin
            hi = $urandom_range(tot, 1);
            lo = $urandom_range(hi - 1, 0);
        end else if (kind < 95) begin
            lo = $urandom();
            hi = $urandom();
        end else begin
            lo = $urandom();
            hi = $urandom();
            tot = 0;
        end
        send_symbol(lo, hi, tot, $urandom_range(19) == 0);
    endtask

    task automatic drain();
        sym_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (200) @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, zero total, bad bounds, narrow symbols, end of message.
        send_symbol(32'd0, 32'd1, 32'd1, 1'b0);
        send_symbol(32'd0, 32'd1, 32'hFFFF_FFFF, 1'b0);
        send_symbol(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_symbol(32'd0, 32'd0, 32'd0, 1'b0);
        send_symbol(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_symbol(32'd1, 32'd2, 32'd3, 1'b1);
        send_symbol(32'd5, 32'd3, 32'd7, 1'b0);
        send_symbol(32'd2, 32'd9, 32'd4, 1'b0);
        send_symbol(32'hFFFF_FFFF, 32'd0, 32'd1, 1'b1);
        // Symbols around the middle push the interval into underflow until it saturates.
        for (int i = 0; i < 12; i++) begin
            send_symbol(32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 1'b0);
        end
        send_symbol(32'd0, 32'd1, 32'd2, 1'b1);
        send_symbol(32'hAAAA_AAAA, 32'hD555_5555, 32'hFFFF_FFFF, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? 47 : 0;
            stall_pct = (ph == 2 || ph == 3) ? 47 : 0;
            if (ph == 3) begin
                send_idle = 6;
                stall_pct = 6;
            end
            if (ph == 2) begin
                hold_off = 3000;
            end
            for (int i = 0; i < 50; i++) begin
                random_symbol();
            end
            send_symbol(32'd0, 32'd1, 32'd2, 1'b1);
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
